// ----- rtl/core/sfcp_pkg.sv -----
// shared types and constants for the sync frame checksum parser
`timescale 1ns / 1ps

package sfcp_pkg;

  localparam int unsigned IdxW = 6;

  localparam logic [7:0]      SyncFirst    = 8'haf;
  localparam logic [7:0]      SyncSecond   = 8'hc1;
  localparam logic [IdxW-1:0] SumLowIdx    = 6'd4;
  localparam logic [IdxW-1:0] SumHighIdx   = 6'd5;
  localparam logic [IdxW-1:0] PayloadIdx   = 6'd6;
  localparam logic [IdxW-1:0] XLowIdx      = 6'd8;
  localparam logic [IdxW-1:0] XHighIdx     = 6'd9;
  localparam logic [IdxW-1:0] YLowIdx      = 6'd10;
  localparam logic [IdxW-1:0] YHighIdx     = 6'd11;
  localparam logic [IdxW-1:0] FirstDataIdx = 6'd2;
  localparam logic [15:0]     ErrorWord    = 16'h0101;

  typedef struct packed {
    logic        coord_error;
    logic [15:0] y_coord;
    logic [15:0] x_coord;
    logic        checksum_ok;
  } sfcp_result_t;

endpackage

// ----- rtl/core/sfcp_parser.sv -----
// frame capture, checksum compare and last-good coordinate store
`timescale 1ns / 1ps

module sfcp_parser
  import sfcp_pkg::*;
#(
  parameter int FRAME_LEN = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         byte_valid,
  input  logic [7:0]   rx_byte,
  input  logic         transfer_start,
  output logic         res_valid,
  output sfcp_result_t res
);

  localparam logic [IdxW-1:0] FrameLenIdx = IdxW'(FRAME_LEN);

  logic [7:0]      prev_byte_r, prev_byte_nxt;
  logic            prev_valid_r, prev_valid_nxt;
  logic            seen_r, seen_nxt;
  logic            active_r, active_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic [15:0]     exp_sum_r, exp_sum_nxt;
  logic [15:0]     run_sum_r, run_sum_nxt;
  logic [15:0]     frame_x_r, frame_x_nxt;
  logic [15:0]     frame_y_r, frame_y_nxt;
  logic [15:0]     good_x_r, good_x_nxt;
  logic [15:0]     good_y_r, good_y_nxt;

  logic            prev_valid_e, seen_e, active_e;
  logic [IdxW-1:0] idx_e;
  logic            ok;

  always_comb begin
    prev_valid_e = prev_valid_r & ~transfer_start;
    seen_e       = seen_r & ~transfer_start;
    active_e     = active_r & ~transfer_start;
    idx_e        = transfer_start ? '0 : idx_r;

    prev_byte_nxt  = prev_byte_r;
    prev_valid_nxt = prev_valid_r;
    seen_nxt       = seen_r;
    active_nxt     = active_r;
    idx_nxt        = idx_r;
    exp_sum_nxt    = exp_sum_r;
    run_sum_nxt    = run_sum_r;
    frame_x_nxt    = frame_x_r;
    frame_y_nxt    = frame_y_r;
    good_x_nxt     = good_x_r;
    good_y_nxt     = good_y_r;
    ok             = 1'b0;
    res_valid      = 1'b0;

    if (byte_valid) begin
      seen_nxt   = seen_e;
      active_nxt = active_e;
      idx_nxt    = idx_e;
      if (active_e) begin
        if (idx_e == SumLowIdx) exp_sum_nxt[7:0] = rx_byte;
        if (idx_e == SumHighIdx) exp_sum_nxt[15:8] = rx_byte;
        if (idx_e >= PayloadIdx) run_sum_nxt = run_sum_r + {8'd0, rx_byte};
        if (idx_e == XLowIdx) frame_x_nxt[7:0] = rx_byte;
        if (idx_e == XHighIdx) frame_x_nxt[15:8] = rx_byte;
        if (idx_e == YLowIdx) frame_y_nxt[7:0] = rx_byte;
        if (idx_e == YHighIdx) frame_y_nxt[15:8] = rx_byte;
        idx_nxt = idx_e + 1'b1;
        if (idx_nxt >= FrameLenIdx) begin
          ok = (run_sum_nxt == exp_sum_nxt);
          if (ok) begin
            good_x_nxt = frame_x_nxt;
            good_y_nxt = frame_y_nxt;
          end
          active_nxt = 1'b0;
          res_valid  = 1'b1;
        end
      end else if (!seen_e && prev_valid_e && prev_byte_r == SyncFirst
                   && rx_byte == SyncSecond) begin
        seen_nxt    = 1'b1;
        active_nxt  = 1'b1;
        idx_nxt     = FirstDataIdx;
        exp_sum_nxt = '0;
        run_sum_nxt = '0;
        frame_x_nxt = '0;
        frame_y_nxt = '0;
      end
      prev_byte_nxt  = rx_byte;
      prev_valid_nxt = 1'b1;
    end

    res.checksum_ok = ok;
    res.x_coord     = good_x_nxt;
    res.y_coord     = good_y_nxt;
    res.coord_error = (good_x_nxt == ErrorWord) && (good_y_nxt == ErrorWord);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_byte_r  <= '0;
      prev_valid_r <= 1'b0;
      seen_r       <= 1'b0;
      active_r     <= 1'b0;
      idx_r        <= '0;
      exp_sum_r    <= '0;
      run_sum_r    <= '0;
      frame_x_r    <= '0;
      frame_y_r    <= '0;
      good_x_r     <= '0;
      good_y_r     <= '0;
    end else begin
      prev_byte_r  <= prev_byte_nxt;
      prev_valid_r <= prev_valid_nxt;
      seen_r       <= seen_nxt;
      active_r     <= active_nxt;
      idx_r        <= idx_nxt;
      exp_sum_r    <= exp_sum_nxt;
      run_sum_r    <= run_sum_nxt;
      frame_x_r    <= frame_x_nxt;
      frame_y_r    <= frame_y_nxt;
      good_x_r     <= good_x_nxt;
      good_y_r     <= good_y_nxt;
    end
  end

endmodule

// ----- rtl/core/sfcp_out_buf.sv -----
// result register with skid stage
`timescale 1ns / 1ps

module sfcp_out_buf
  import sfcp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  sfcp_result_t push_data,
  output logic         can_take,
  output logic         out_valid,
  input  logic         out_ready,
  output sfcp_result_t out_data
);

  logic         main_v_r, main_v_nxt;
  logic         skid_v_r, skid_v_nxt;
  sfcp_result_t main_d_r, main_d_nxt;
  sfcp_result_t skid_d_r, skid_d_nxt;
  logic         pop;

  always_comb begin
    pop        = main_v_r & out_ready;
    main_v_nxt = main_v_r;
    main_d_nxt = main_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (!main_v_r || pop) begin
      if (skid_v_r) begin
        main_v_nxt = 1'b1;
        main_d_nxt = skid_d_r;
        skid_v_nxt = push;
        skid_d_nxt = push_data;
      end else begin
        main_v_nxt = push;
        main_d_nxt = push_data;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign can_take  = ~skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

endmodule

// ----- rtl/core/sync_frame_checksum_coord_parser_top.sv -----
// top level of the sync frame checksum parser
//
//   port group | dir | tdata                  | tuser
//   in_        | in  | rx_byte [7:0]          | transfer_start [0]
//   out_       | out | x [15:0], y [31:16]    | checksum_ok [0], coord_error [1]
//
// one byte per cycle while in_tready is high; the byte is parsed in the accept
// cycle and a result lands in the output or skid register on the next edge
// a result is emitted only on the last byte of a frame
// in_tready drops only while the skid stage holds a result (output stalled)
// synchronous active-low reset clears parser state and the output stage
`timescale 1ns / 1ps

module sync_frame_checksum_coord_parser_top
  import sfcp_pkg::*;
#(
  parameter int FRAME_LEN = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte [7:0]
  input  logic [0:0]  in_tuser,   // transfer_start [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // x_coord [15:0], y_coord [31:16]
  output logic [1:0]  out_tuser   // checksum_ok [0], coord_error [1]
);

  logic         in_xfer;
  logic         res_valid;
  sfcp_result_t res;
  sfcp_result_t out_res;

  assign in_xfer = in_tvalid & in_tready;

  sfcp_parser #(
    .FRAME_LEN(FRAME_LEN)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_valid    (in_xfer),
    .rx_byte       (in_tdata),
    .transfer_start(in_tuser[0]),
    .res_valid     (res_valid),
    .res           (res)
  );

  sfcp_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_data(res),
    .can_take (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (out_res)
  );

  assign out_tdata = {out_res.y_coord, out_res.x_coord};
  assign out_tuser = {out_res.coord_error, out_res.checksum_ok};

endmodule

// ----- test/tb_sync_frame_checksum_coord_parser_top.sv -----
// self-checking testbench for the sync frame checksum coordinate parser
`timescale 1ns / 1ps

module tb_sync_frame_checksum_coord_parser_top;
  import sfcp_pkg::*;

  localparam int FrameLen    = 20;
  localparam int GapMax      = 18;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 10;
  localparam int CycleLimit  = 200000;
  localparam int RandomBytes = 400;

  typedef enum int {FillRandom, FillZero, FillOnes} fill_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // rx_byte [7:0]
  logic [0:0]  in_tuser;   // transfer_start [0]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // x_coord [15:0], y_coord [31:16]
  logic [1:0]  out_tuser;  // checksum_ok [0], coord_error [1]

  // parser state kept alongside the block
  logic [7:0]      last_byte;
  logic            last_byte_valid;
  logic            sync_found;
  logic            in_frame;
  logic [IdxW-1:0] frame_pos;
  logic [15:0]     frame_csum;
  logic [15:0]     payload_sum;
  logic [15:0]     cap_x;
  logic [15:0]     cap_y;
  logic [15:0]     held_x;
  logic [15:0]     held_y;

  sfcp_result_t expected_reports[$];

  bit gaps_on;
  bit hold_req;
  int fail_count;
  int bytes_sent;
  int results_checked;
  int ok_count;
  int error_state_count;
  int cycle_count;

  sync_frame_checksum_coord_parser_top #(
    .FRAME_LEN(FrameLen)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void predict_frame_byte(input logic [7:0] b, input logic start);
    sfcp_result_t rep;
    logic ok;
    if (start) begin
      last_byte_valid = 1'b0;
      sync_found      = 1'b0;
      in_frame        = 1'b0;
      frame_pos       = '0;
    end
    if (in_frame) begin
      if (frame_pos == SumLowIdx) frame_csum[7:0] = b;
      else if (frame_pos == SumHighIdx) frame_csum[15:8] = b;
      if (frame_pos >= PayloadIdx) payload_sum = payload_sum + 16'(b);
      if (frame_pos == XLowIdx) cap_x[7:0] = b;
      else if (frame_pos == XHighIdx) cap_x[15:8] = b;
      else if (frame_pos == YLowIdx) cap_y[7:0] = b;
      else if (frame_pos == YHighIdx) cap_y[15:8] = b;
      frame_pos = frame_pos + 1'b1;
      if (frame_pos >= FrameLen) begin
        ok = (payload_sum == frame_csum);
        if (ok) begin
          held_x = cap_x;
          held_y = cap_y;
        end
        in_frame = 1'b0;
        rep.checksum_ok = ok;
        rep.x_coord     = held_x;
        rep.y_coord     = held_y;
        rep.coord_error = (held_x == ErrorWord) && (held_y == ErrorWord);
        expected_reports.push_back(rep);
      end
    end else if (!sync_found && last_byte_valid && last_byte == SyncFirst &&
                 b == SyncSecond) begin
      sync_found  = 1'b1;
      in_frame    = 1'b1;
      frame_pos   = FirstDataIdx;
      frame_csum  = '0;
      payload_sum = '0;
      cap_x       = '0;
      cap_y       = '0;
    end
    last_byte       = b;
    last_byte_valid = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h (cycle %0d)", what, got, want, cycle_count);
    fail_count++;
  endtask

  task automatic check_report();
    sfcp_result_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch("report with none pending", out_tdata, '0);
      return;
    end
    want = expected_reports.pop_front();
    results_checked++;
    if (want.checksum_ok) ok_count++;
    if (want.coord_error) error_state_count++;
    if (out_tuser[0] !== want.checksum_ok)
      report_mismatch("checksum_ok", 32'(out_tuser[0]), 32'(want.checksum_ok));
    if (out_tdata[15:0] !== want.x_coord)
      report_mismatch("x_coord", 32'(out_tdata[15:0]), 32'(want.x_coord));
    if (out_tdata[31:16] !== want.y_coord)
      report_mismatch("y_coord", 32'(out_tdata[31:16]), 32'(want.y_coord));
    if (out_tuser[1] !== want.coord_error)
      report_mismatch("coord_error", 32'(out_tuser[1]), 32'(want.coord_error));
  endtask

  // results are checked before the byte of the same edge is predicted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_report();
      if (in_tvalid && in_tready) predict_frame_byte(in_tdata, in_tuser[0]);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout with %0d reports pending", expected_reports.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver side
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        stall = gaps_on ? $urandom_range(0, GapMax) : 0;
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid && !hold_req);
      @(negedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    gap = gaps_on ? $urandom_range(0, GapMax) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= b;
    in_tuser[0] <= start;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [15:0] x, input logic [15:0] y, input bit good,
                            input fill_t fill, input bit new_transfer, input int len);
    logic [7:0]  fb [FrameLen];
    logic [15:0] sum;
    logic [15:0] csum;
    int i;
    sum = '0;
    fb[0] = SyncFirst;
    fb[1] = SyncSecond;
    for (i = 2; i < FrameLen; i++) begin
      case (fill)
        FillZero: fb[i] = 8'h00;
        FillOnes: fb[i] = 8'hff;
        default:  fb[i] = 8'($urandom);
      endcase
    end
    fb[XLowIdx]  = x[7:0];
    fb[XHighIdx] = x[15:8];
    fb[YLowIdx]  = y[7:0];
    fb[YHighIdx] = y[15:8];
    for (i = PayloadIdx; i < FrameLen; i++) sum = sum + 16'(fb[i]);
    if (good) csum = sum;
    else if (fill == FillZero) csum = sum ^ 16'hffff;
    else csum = sum ^ 16'($urandom_range(1, 16'hffff));
    fb[SumLowIdx]  = csum[7:0];
    fb[SumHighIdx] = csum[15:8];
    for (i = 0; i < len; i++) send_byte(fb[i], new_transfer && (i == 0));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_no_valid_frame_yet();
    send_frame(16'h1234, 16'h5678, 1'b0, FillZero, 1'b1, FrameLen);
  endtask

  task automatic test_good_frames();
    send_frame(16'hffff, 16'h0000, 1'b1, FillOnes, 1'b1, FrameLen);
    send_frame(16'h0000, 16'hffff, 1'b1, FillZero, 1'b1, FrameLen);
    send_frame(16'($urandom), 16'($urandom), 1'b1, FillRandom, 1'b1, FrameLen);
  endtask

  task automatic test_bad_checksum();
    send_frame(16'($urandom), 16'($urandom), 1'b0, FillRandom, 1'b1, FrameLen);
    send_frame(16'hffff, 16'hffff, 1'b0, FillOnes, 1'b1, FrameLen);
  endtask

  task automatic test_error_state();
    send_frame(ErrorWord, ErrorWord, 1'b1, FillRandom, 1'b1, FrameLen);
    send_frame(16'($urandom), 16'($urandom), 1'b0, FillRandom, 1'b1, FrameLen);
    send_frame(ErrorWord, ErrorWord + 16'd1, 1'b1, FillRandom, 1'b1, FrameLen);
  endtask

  task automatic test_cut_frame();
    send_frame(16'($urandom), 16'($urandom), 1'b1, FillRandom, 1'b1, 2);
    send_frame(16'($urandom), 16'($urandom), 1'b1, FillRandom, 1'b1, FrameLen - 1);
    send_frame(16'($urandom), 16'($urandom), 1'b1, FillRandom, 1'b1, FrameLen);
  endtask

  task automatic test_later_sync_ignored();
    send_frame(16'($urandom), 16'($urandom), 1'b1, FillRandom, 1'b1, FrameLen);
    send_frame(16'($urandom), 16'($urandom), 1'b1, FillRandom, 1'b0, FrameLen);
    send_frame(16'($urandom), 16'($urandom), 1'b1, FillRandom, 1'b1, FrameLen);
  endtask

  // a sync pair split by a new transfer must not start a frame
  task automatic test_sync_across_transfers();
    int i;
    send_byte(8'h00, 1'b1);
    send_byte(SyncFirst, 1'b0);
    send_byte(SyncSecond, 1'b1);
    for (i = 0; i < FrameLen; i++) send_byte(8'($urandom), 1'b0);
    send_frame(16'($urandom), 16'($urandom), 1'b1, FillRandom, 1'b1, FrameLen);
  endtask

  task automatic test_output_hold_off();
    int i;
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    for (i = 0; i < 6; i++)
      send_frame(16'($urandom), 16'($urandom), 1'b1, FillRandom, 1'b1, FrameLen);
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int target;
    int noise;
    int kind;
    int i;
    logic [15:0] x;
    logic [15:0] y;
    target = bytes_sent + RandomBytes;
    while (bytes_sent < target) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      noise   = $urandom_range(0, 3);
      kind    = $urandom_range(0, 9);
      if ($urandom_range(0, 7) == 0) begin
        x = ErrorWord;
        y = ErrorWord;
      end else begin
        x = 16'($urandom);
        y = 16'($urandom);
      end
      for (i = 0; i < noise; i++) send_byte(8'($urandom), i == 0);
      case (kind)
        0: send_frame(x, y, 1'b0, FillRandom, noise == 0, FrameLen);
        1: send_frame(x, y, 1'b1, FillRandom, noise == 0, $urandom_range(2, FrameLen - 1));
        default: send_frame(x, y, 1'b1, FillRandom, noise == 0, FrameLen);
      endcase
      if ($urandom_range(0, 3) == 0) begin
        send_byte(SyncFirst, 1'b0);
        send_byte(SyncSecond, 1'b0);
        for (i = 0; i < $urandom_range(0, 4); i++) send_byte(8'($urandom), 1'b0);
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    gaps_on     = 1'b1;
    hold_req    = 1'b0;
    last_byte       = '0;
    last_byte_valid = 1'b0;
    sync_found      = 1'b0;
    in_frame        = 1'b0;
    frame_pos       = '0;
    frame_csum      = '0;
    payload_sum     = '0;
    cap_x           = '0;
    cap_y           = '0;
    held_x          = '0;
    held_y          = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_no_valid_frame_yet();
    test_good_frames();
    test_bad_checksum();
    test_error_state();
    test_cut_frame();
    test_later_sync_ignored();
    test_sync_across_transfers();
    test_output_hold_off();
    test_random_traffic();
    wait_drained();

    $display("sent %0d bytes incl. cut frames, split sync pairs and a long output stall",
             bytes_sent);
    $display("checked %0d frame reports: %0d with good checksum, %0d in error state",
             results_checked, ok_count, error_state_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
